/* rtl/acid_bass_synth_voice_assert.svh */
// Assertion macros for the bass voice.
`ifndef ACID_BASS_SYNTH_VOICE_ASSERT_SVH
`define ACID_BASS_SYNTH_VOICE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ABSV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/absv_pkg.sv */
// Shared types, constants and constant tables of the bass voice.
package absv_pkg;

    localparam int NUM_VOICES = 6;
    localparam int SINE_DEPTH = 256;
    localparam int TANH_DEPTH = 256;
    localparam int SINE_LOG   = $clog2(SINE_DEPTH);
    localparam int TANH_LOG   = $clog2(TANH_DEPTH);
    localparam int VIDX_W     = $clog2(NUM_VOICES);

    // field widths
    localparam int KIND_W   = 2;
    localparam int NOTE_W   = 23;
    localparam int AUDIO_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // datapath widths
    localparam int PH_W   = 24;
    localparam int INC_W  = 32;
    localparam int ENV_W  = 24;
    localparam int CUT_W  = 15;
    localparam int FQ_W   = 18;
    localparam int TAB_W  = 31;
    localparam int SUM_W  = $clog2(NUM_VOICES + 1) + 26;
    localparam int OSC_W  = 27;
    localparam int HP_W   = 32;
    localparam int LP_W   = 32;
    localparam int BP_W   = 26;
    localparam int BPN_W  = 33;
    localparam int X_W    = 35;
    localparam int FRAC_W = 26;
    localparam int A_W    = 33;
    localparam int B_W    = 34;
    localparam int P_W    = A_W + B_W;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_AMOUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUTOFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OSC_MODE    = 3'd5;

    // oscillator modes
    localparam logic [1:0] OSC_SAW    = 2'd0;
    localparam logic [1:0] OSC_SQUARE = 2'd1;
    localparam logic [1:0] OSC_SUPER  = 2'd2;

    // operation sequence: one detune product per voice, then the rest
    localparam int OP_W = $clog2(NUM_VOICES + 11);
    localparam logic [OP_W-1:0] OP_DIV   = OP_W'(NUM_VOICES);
    localparam logic [OP_W-1:0] OP_GLIDE = OP_W'(NUM_VOICES + 1);
    localparam logic [OP_W-1:0] OP_DECAY = OP_W'(NUM_VOICES + 2);
    localparam logic [OP_W-1:0] OP_CUT   = OP_W'(NUM_VOICES + 3);
    localparam logic [OP_W-1:0] OP_SINE  = OP_W'(NUM_VOICES + 4);
    localparam logic [OP_W-1:0] OP_DAMP  = OP_W'(NUM_VOICES + 5);
    localparam logic [OP_W-1:0] OP_BP    = OP_W'(NUM_VOICES + 6);
    localparam logic [OP_W-1:0] OP_LP    = OP_W'(NUM_VOICES + 7);
    localparam logic [OP_W-1:0] OP_DRIVE = OP_W'(NUM_VOICES + 8);
    localparam logic [OP_W-1:0] OP_TANH  = OP_W'(NUM_VOICES + 9);
    localparam logic [OP_W-1:0] OP_GAIN  = OP_W'(NUM_VOICES + 10);
    localparam logic [OP_W-1:0] OP_LAST  = OP_GAIN;

    // fixed-point constants
    localparam logic [ENV_W-1:0] ENV_FLOOR  = 24'd419;
    localparam logic [ENV_W-1:0] ENV_ONE    = 24'd4194304;
    localparam logic [ENV_W-1:0] ENV_TWO    = 24'd8388608;
    localparam logic [CUT_W-1:0] MAX_CUTOFF = 15'd29491;
    localparam logic [15:0]      MIN_DAMP   = 16'd3932;
    localparam logic [22:0]      GLIDE_COEF = 23'd4294967;
    localparam logic [16:0]      DRIVE_COEF = 17'd85197;
    localparam logic [14:0]      GAIN_COEF  = 15'd19661;
    localparam logic [INC_W-1:0] INC_RESET  = 32'd10713070;
    localparam logic signed [LP_W-1:0] LP_LIMIT = 32'sd838860800;
    localparam logic signed [PH_W+1:0] SAW_ONE  = 26'sd16777216;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << 32) + NUM_VOICES - 2) / (NUM_VOICES - 1);
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint Q30_ONE     = 64'd1073741824;

    typedef struct packed {
        logic [CUT_W-1:0] cutoff_base;
        logic [15:0]      env_amount;
        logic [CUT_W-1:0] min_cutoff;
        logic [15:0]      damping;
        logic [23:0]      decay_coeff;
        logic [1:0]       osc_mode;
    } t_cfg;

    typedef struct packed {
        logic            tick_start;
        logic            note;
        logic            rel;
        logic            mul;
        logic            wb;
        logic [OP_W-1:0] op;
        logic            load_out;
        logic            out_zero;
    } t_cmd;

    typedef struct packed {
        logic silent;
    } t_stat;

    typedef logic [16:0]      t_detune [NUM_VOICES];
    typedef logic [PH_W-1:0]  t_phases [NUM_VOICES];
    typedef logic [TAB_W-1:0] t_sine_tab [SINE_DEPTH+1];
    typedef logic [TAB_W-1:0] t_tanh_tab [TANH_DEPTH+1];

    // restoring division, used only while the tables are built
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_detune build_detune();
        logic [16:0] base [6];
        t_detune     res;
        base = '{17'd64291, 17'd66781, 17'd64750, 17'd66322, 17'd65110, 17'd65962};
        for (int i = 0; i < NUM_VOICES; i++) res[i] = base[i % 6];
        return res;
    endfunction

    function automatic t_phases build_phase_reset();
        t_phases res;
        for (int i = 0; i < NUM_VOICES; i++)
            res[i] = PH_W'(((longint'(((i + 1) * 137) % 1000)) << 24) / 1000);
        return res;
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab         tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x    = longint'(k) * HALF_PI_Q30 / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 5; n++) begin
                term = udiv64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            if (sum > Q30_ONE) sum = Q30_ONE;
            tab[k] = TAB_W'(sum);
        end
        return tab;
    endfunction

    function automatic t_tanh_tab build_tanh();
        t_tanh_tab       tab;
        longint          h;
        longint          h2;
        longint          h3;
        longint          h5;
        longint          h7;
        longint          th;
        longint          t;
        longint unsigned num;
        longint unsigned den;
        h  = longint'((64'd4 << 30) / TANH_DEPTH);
        h2 = (h * h) >> 30;
        h3 = (h2 * h) >> 30;
        h5 = (h3 * h2) >> 30;
        h7 = (h5 * h2) >> 30;
        th = h - h3 / 3 + (2 * h5) / 15 - (17 * h7) / 315;
        tab[0] = '0;
        for (int k = 0; k < TANH_DEPTH; k++) begin
            t   = longint'(tab[k]);
            num = longint'(t + th) << 30;
            den = Q30_ONE + ((t * th) >> 30);
            tab[k+1] = TAB_W'(udiv64(num, den));
        end
        return tab;
    endfunction

    localparam t_detune   DETUNE_TAB  = build_detune();
    localparam t_phases   PHASE_RESET = build_phase_reset();
    localparam t_sine_tab SINE_TAB    = build_sine();
    localparam t_tanh_tab TANH_TAB    = build_tanh();

    // saw value of a phase: 2*phase - 1 in Q24
    function automatic logic signed [PH_W+1:0] saw_of(input logic [PH_W-1:0] ph);
        return $signed({1'b0, ph, 1'b0}) - SAW_ONE;
    endfunction

endpackage

/* rtl/absv_ifs.sv */
// Channel interfaces of the bass voice: note/tick input, audio output, register writes.
interface absv_in_if import absv_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [NOTE_W-1:0] note_increment;
    logic              accent;
    logic              slide;
    modport source (output valid, kind, note_increment, accent, slide, input ready);
    modport sink   (input valid, kind, note_increment, accent, slide, output ready);
endinterface

interface absv_out_if import absv_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [AUDIO_W-1:0] audio_sample;
    modport source (output valid, audio_sample, input ready);
    modport sink   (input valid, audio_sample, output ready);
endinterface

interface absv_cfg_if import absv_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/acid_bass_synth_voice.sv */
// Top level of the monophonic bass voice: register file, sequencer and datapath.
//
// Use:
//   i_in   carries items: kind 0 is a sample tick, 1 a note start (note_increment,
//          accent, slide), 2 a release; kind 3 is dropped. Only ticks give a
//          result, one audio_sample each on o_out (Q19, two's complement).
//   i_cfg  writes the six voice registers by index; it is always ready and is
//          meant to be used while the voice is idle. Unknown indexes are ignored.
// Sequence:
//   Note and release transfers leave the voice idle, so it is ready again
//   the next cycle. A tick runs NUM_VOICES + 11 products on the one shared
//   multiplier, each a multiply step then a writeback step, between a start
//   step and an output step; the voice takes no new item until it is done.
//   A tick of a silent voice (gate off, envelope below floor) gives zero
//   and skips the products. The products and output stalls set the tick rate.
// Reset (synchronous, active low) loads the register defaults, the 110 Hz
// increment and the spread supersaw phases; the filter starts at rest.
// Output stall: a result waits in the output register; the next tick runs
// and then holds in its last step until the output register is free.
`include "acid_bass_synth_voice_assert.svh"

module acid_bass_synth_voice import absv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    absv_in_if.sink       i_in,
    absv_out_if.source    o_out,
    absv_cfg_if.sink      i_cfg
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    // register file, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cutoff_base <= 15'd1189;
            r_cfg.env_amount  <= 16'd594;
            r_cfg.min_cutoff  <= 15'd74;
            r_cfg.damping     <= 16'd19275;
            r_cfg.decay_coeff <= 24'd16773045;
            r_cfg.osc_mode    <= OSC_SAW;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CUTOFF_BASE: r_cfg.cutoff_base <= i_cfg.data[CUT_W-1:0];
                CFG_ENV_AMOUNT:  r_cfg.env_amount  <= i_cfg.data[15:0];
                CFG_MIN_CUTOFF:  r_cfg.min_cutoff  <= i_cfg.data[CUT_W-1:0];
                CFG_DAMPING:     r_cfg.damping     <= i_cfg.data[15:0];
                CFG_DECAY_COEFF: r_cfg.decay_coeff <= i_cfg.data[23:0];
                CFG_OSC_MODE:    r_cfg.osc_mode    <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    absv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_kind      (i_in.kind),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // voice datapath
    absv_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .i_note_increment (i_in.note_increment),
        .i_accent         (i_in.accent),
        .i_slide          (i_in.slide),
        .o_stat           (stat),
        .o_audio_sample   (o_out.audio_sample)
    );

    `ABSV_ASSERT_NEXT(a_tick_busy, i_in.valid && i_in.ready && i_in.kind == KIND_TICK, !i_in.ready, "tick transfer did not leave the voice busy")
    `ABSV_ASSERT_NEXT(a_mul_wb, cmd.mul, cmd.wb, "multiply step not followed by writeback")
    `ABSV_ASSERT_NEXT(a_load_valid, cmd.load_out, o_out.valid, "loaded result not presented")
    `ABSV_ASSERT_NEXT(a_silent_zero, cmd.load_out && cmd.out_zero, o_out.audio_sample == '0, "silent tick gave a nonzero sample")

endmodule

/* rtl/absv_ctrl.sv */
// Sequencer of the bass voice: item decode, multiply/writeback steps, output handshake.
module absv_ctrl import absv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_kind,
    input  logic              i_out_ready,
    input  t_stat             i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_WB   = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;
    logic            r_zero, n_zero;
    logic            r_ovalid, n_ovalid;
    logic            accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_zero   = r_zero;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.op = r_op;
        o_cmd.out_zero = r_zero;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_TICK) begin
                        n_op = '0;
                        if (i_stat.silent) begin
                            n_zero  = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_zero = 1'b0;
                            o_cmd.tick_start = 1'b1;
                            n_state = S_MUL;
                        end
                    end else if (i_kind == KIND_NOTE) begin
                        o_cmd.note = 1'b1;
                    end else if (i_kind == KIND_RELEASE) begin
                        o_cmd.rel = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (r_op == OP_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_op    = r_op + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= '0;
            r_zero   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_zero   <= n_zero;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

/* rtl/absv_dp.sv */
// Datapath of the bass voice: voice state, shared multiplier, filter and table lookups.
module absv_dp import absv_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  t_cmd                      i_cmd,
    input  logic [NOTE_W-1:0]         i_note_increment,
    input  logic                      i_accent,
    input  logic                      i_slide,
    output t_stat                     o_stat,
    output logic signed [AUDIO_W-1:0] o_audio_sample
);

    // voice state
    logic [PH_W-1:0]  r_main;
    logic [PH_W-1:0]  r_det [NUM_VOICES];
    logic [INC_W-1:0] r_cur, r_tgt;
    logic [ENV_W-1:0] r_env;
    logic             r_gate;
    logic signed [LP_W-1:0] r_lp;
    logic signed [BP_W-1:0] r_bp;

    // per-tick working registers
    logic signed [P_W-1:0]   r_prod;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [OSC_W-1:0] r_osc;
    logic [CUT_W-1:0]        r_cut;
    logic [TAB_W-1:0]        r_slo;
    logic [FQ_W-1:0]         r_fq;
    logic signed [HP_W-1:0]  r_hp;
    logic signed [BPN_W-1:0] r_bpn;
    logic [TAB_W-1:0]        r_tlo, r_tdif;
    logic [FRAC_W-1:0]       r_tfrac;
    logic                    r_xneg;
    logic signed [AUDIO_W-1:0] r_res, r_audio;

    logic signed [A_W-1:0]   mul_a;
    logic signed [B_W-1:0]   mul_b;
    logic [VIDX_W-1:0]       vidx;
    logic signed [INC_W:0]   diff;
    logic [INC_W-1:0]        abs_diff;
    logic [SUM_W-1:0]        abs_sum;
    logic [CUT_W+SINE_LOG:0] spos;
    logic [SINE_LOG:0]       sidx;
    logic [15:0]             sfrac;
    logic [15:0]             damp_q;
    logic [PH_W-1:0]         main_new;
    logic signed [PH_W+1:0]  main_saw;
    logic [PH_W-1:0]         det_new;
    logic [CUT_W+3:0]        csum;
    logic [CUT_W+3:0]        cut_raised;
    logic [31:0]             fq_sum;
    logic signed [LP_W+1:0]  lp_new;
    logic signed [X_W-1:0]   x_drv;
    logic [X_W-1:0]          x_mag;
    logic [X_W-1:0]          t_idx;
    logic [TANH_LOG-1:0]     t_ix;
    logic [31:0]             y_sum;
    logic [BP_W-2:0]         y_out;

    assign o_stat.silent  = !r_gate && (r_env < ENV_FLOOR);
    assign o_audio_sample = r_audio;

    assign vidx     = i_cmd.op[VIDX_W-1:0];
    assign diff     = $signed({1'b0, r_tgt}) - $signed({1'b0, r_cur});
    assign abs_diff = diff[INC_W] ? INC_W'(-diff) : diff[INC_W-1:0];
    assign abs_sum  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign spos     = {r_cut, (SINE_LOG + 1)'(0)};
    assign sidx     = (SINE_LOG + 1)'(spos[CUT_W+SINE_LOG:16]);
    assign sfrac    = spos[15:0];
    assign damp_q   = (i_cfg.damping < MIN_DAMP) ? MIN_DAMP : i_cfg.damping;
    assign main_new = r_main + r_cur[INC_W-1:8];
    assign main_saw = saw_of(main_new);
    assign det_new  = r_det[vidx] + r_prod[47:24];
    assign csum     = {4'b0, i_cfg.cutoff_base} + {1'b0, r_prod[39:22]};
    // raise to the minimum first, then lower to the maximum
    assign cut_raised = (csum < {4'b0, i_cfg.min_cutoff}) ? {4'b0, i_cfg.min_cutoff} : csum;
    assign fq_sum   = {1'b0, r_slo} + {1'b0, r_prod[16 +: TAB_W]} + 32'd4096;
    assign lp_new   = LP_W'(0) + r_lp + $signed(r_prod[16 +: LP_W+2]);
    assign x_drv    = $signed(r_prod[16 +: X_W]);
    assign x_mag    = x_drv[X_W-1] ? X_W'(-x_drv) : X_W'(x_drv);
    assign t_idx    = x_mag >> (FRAC_W - TANH_LOG);
    assign t_ix     = t_idx[TANH_LOG-1:0];
    assign y_sum    = {1'b0, r_tlo} + {1'b0, r_prod[26 +: TAB_W]} + 32'd32;
    assign y_out    = y_sum[6 +: BP_W-1];

    // operand select of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.op < OP_DIV) begin
            mul_a = A_W'($signed({1'b0, r_cur}));
            mul_b = B_W'($signed({1'b0, DETUNE_TAB[vidx]}));
        end else begin
            case (i_cmd.op)
                OP_DIV: begin
                    mul_a = A_W'($signed({1'b0, abs_sum}));
                    mul_b = B_W'(DIV_RECIP);
                end
                OP_GLIDE: begin
                    mul_a = A_W'($signed({1'b0, abs_diff}));
                    mul_b = B_W'($signed({1'b0, GLIDE_COEF}));
                end
                OP_DECAY: begin
                    mul_a = A_W'($signed({1'b0, r_env}));
                    mul_b = B_W'($signed({1'b0, i_cfg.decay_coeff}));
                end
                OP_CUT: begin
                    mul_a = A_W'($signed({1'b0, i_cfg.env_amount}));
                    mul_b = B_W'($signed({1'b0, r_env}));
                end
                OP_SINE: begin
                    mul_a = A_W'($signed({1'b0, SINE_TAB[sidx + 1'b1] - SINE_TAB[sidx]}));
                    mul_b = B_W'($signed({1'b0, sfrac}));
                end
                OP_DAMP: begin
                    mul_a = A_W'(r_bp);
                    mul_b = B_W'($signed({1'b0, damp_q}));
                end
                OP_BP: begin
                    mul_a = A_W'(r_hp);
                    mul_b = B_W'($signed({1'b0, r_fq}));
                end
                OP_LP: begin
                    mul_a = A_W'(r_bpn);
                    mul_b = B_W'($signed({1'b0, r_fq}));
                end
                OP_DRIVE: begin
                    mul_a = A_W'(r_bpn);
                    mul_b = B_W'($signed({1'b0, DRIVE_COEF}));
                end
                OP_TANH: begin
                    mul_a = A_W'($signed({1'b0, r_tdif}));
                    mul_b = B_W'($signed({1'b0, r_tfrac}));
                end
                OP_GAIN: begin
                    mul_a = A_W'(r_lp);
                    mul_b = B_W'($signed({1'b0, GAIN_COEF}));
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // working registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= mul_a * mul_b;
            if (i_cmd.op == OP_SINE) r_slo <= SINE_TAB[sidx];
        end
        if (i_cmd.tick_start) begin
            r_sum <= SUM_W'(main_saw);
            if (i_cfg.osc_mode == OSC_SQUARE)
                r_osc <= main_saw[PH_W+1] ? OSC_W'(-SAW_ONE) : OSC_W'(SAW_ONE);
            else
                r_osc <= OSC_W'(main_saw);
        end
        if (i_cmd.wb) begin
            if (i_cmd.op < OP_DIV) begin
                if (i_cfg.osc_mode == OSC_SUPER) r_sum <= r_sum + SUM_W'(saw_of(det_new));
            end else begin
                case (i_cmd.op)
                    OP_DIV: begin
                        if (i_cfg.osc_mode == OSC_SUPER)
                            r_osc <= r_sum[SUM_W-1]
                                ? -$signed({1'b0, r_prod[32 +: OSC_W-1]})
                                :  $signed({1'b0, r_prod[32 +: OSC_W-1]});
                    end
                    OP_CUT: begin
                        if (cut_raised > {4'b0, MAX_CUTOFF}) r_cut <= MAX_CUTOFF;
                        else r_cut <= cut_raised[CUT_W-1:0];
                    end
                    OP_SINE: r_fq <= fq_sum[13 +: FQ_W];
                    OP_DAMP: r_hp <= HP_W'(r_osc) - r_lp
                                     - HP_W'($signed(r_prod[P_W-1:16]));
                    OP_BP:   r_bpn <= BPN_W'(r_bp) + $signed(r_prod[16 +: BPN_W]);
                    OP_DRIVE: begin
                        r_xneg <= x_drv[X_W-1];
                        if (t_idx >= X_W'(TANH_DEPTH)) begin
                            r_tlo   <= TANH_TAB[TANH_DEPTH];
                            r_tdif  <= '0;
                            r_tfrac <= '0;
                        end else begin
                            r_tlo   <= TANH_TAB[t_ix];
                            r_tdif  <= TANH_TAB[(TANH_LOG + 1)'(t_ix) + 1'b1] - TANH_TAB[t_ix];
                            r_tfrac <= {x_mag[FRAC_W-TANH_LOG-1:0], TANH_LOG'(0)};
                        end
                    end
                    OP_GAIN: r_res <= $signed(r_prod[21 +: AUDIO_W]);
                    default: ;
                endcase
            end
        end
        if (i_cmd.load_out) r_audio <= i_cmd.out_zero ? '0 : r_res;
    end

    // voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main <= '0;
            for (int i = 0; i < NUM_VOICES; i++) r_det[i] <= PHASE_RESET[i];
            r_cur  <= INC_RESET;
            r_tgt  <= INC_RESET;
            r_env  <= '0;
            r_gate <= 1'b0;
            r_lp   <= '0;
            r_bp   <= '0;
        end else begin
            if (i_cmd.note) begin
                if (!i_slide) r_cur <= {1'b0, i_note_increment, 8'b0};
                r_tgt  <= {1'b0, i_note_increment, 8'b0};
                r_gate <= 1'b1;
                r_env  <= i_accent ? ENV_TWO : ENV_ONE;
            end
            if (i_cmd.rel) r_gate <= 1'b0;
            if (i_cmd.tick_start) r_main <= main_new;
            if (i_cmd.wb) begin
                if (i_cmd.op < OP_DIV) begin
                    if (i_cfg.osc_mode == OSC_SUPER) r_det[vidx] <= det_new;
                end else begin
                    case (i_cmd.op)
                        OP_GLIDE: begin
                            if (diff[INC_W]) r_cur <= r_cur - r_prod[63:32];
                            else r_cur <= r_cur + r_prod[63:32];
                        end
                        OP_DECAY: begin
                            if (r_gate || r_env > ENV_FLOOR) r_env <= r_prod[47:24];
                        end
                        OP_LP: begin
                            if (lp_new > (LP_W + 2)'(LP_LIMIT)) r_lp <= LP_LIMIT;
                            else if (lp_new < -(LP_W + 2)'(LP_LIMIT)) r_lp <= -LP_LIMIT;
                            else r_lp <= lp_new[LP_W-1:0];
                        end
                        OP_TANH: r_bp <= r_xneg ? -$signed({1'b0, y_out})
                                                :  $signed({1'b0, y_out});
                        default: ;
                    endcase
                end
            end
        end
    end

endmodule

/* tb/sv/acid_bass_synth_voice_tb.sv */
// Self-checking testbench of the bass voice: directed table, then random phases.
module acid_bass_synth_voice_tb;
    import absv_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_BAD   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;
    localparam logic [1:0]           OSC_SPARE  = 2'd3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 80;

    logic i_clk;
    logic i_rst_n;

    absv_in_if  in_ch ();
    absv_out_if out_ch ();
    absv_cfg_if cfg_ch ();

    acid_bass_synth_voice dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // 10 unit clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ---------------------------------------------------------------
    // Voice predictor: own copy of registers, state and tables
    // ---------------------------------------------------------------
    logic [14:0] m_cut_base;
    logic [15:0] m_env_amt;
    logic [14:0] m_min_cut;
    logic [15:0] m_damp;
    logic [23:0] m_decay;
    logic [1:0]  m_osc;

    logic [23:0] m_phase;
    logic [23:0] m_dphase [NUM_VOICES];
    logic [31:0] m_cur_inc;
    logic [31:0] m_tgt_inc;
    logic [23:0] m_env;
    logic        m_gate;
    longint      m_lp;
    longint      m_bp;

    longint sine_q30 [SINE_DEPTH+1];
    longint tanh_q30 [TANH_DEPTH+1];
    longint detune_q16 [6];

    logic [23:0] expected_samples [$];
    int          error_count;
    int          cycle_count;
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          rx_hold_len;

    task automatic build_voice_tables();
        longint unsigned x, x2, term, num, den;
        longint sum, h, h2, h3, h5, h7, th, t;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x    = longint'(k) * 64'd1686629713 / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 5; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            if (sum > 64'd1073741824) sum = 64'd1073741824;
            sine_q30[k] = sum;
        end
        h  = longint'((64'd4 << 30) / TANH_DEPTH);
        h2 = (h * h) >>> 30;
        h3 = (h2 * h) >>> 30;
        h5 = (h3 * h2) >>> 30;
        h7 = (h5 * h2) >>> 30;
        th = h - h3 / 3 + (2 * h5) / 15 - (17 * h7) / 315;
        tanh_q30[0] = 0;
        for (int k = 0; k < TANH_DEPTH; k++) begin
            t   = tanh_q30[k];
            num = longint'(t + th) << 30;
            den = 64'd1073741824 + longint'((t * th) >>> 30);
            tanh_q30[k+1] = longint'(num / den);
        end
        detune_q16 = '{64291, 66781, 64750, 66322, 65110, 65962};
    endtask

    task automatic voice_reset();
        m_cut_base = 15'd1189; m_env_amt = 16'd594; m_min_cut = 15'd74;
        m_damp = 16'd19275; m_decay = 24'd16773045; m_osc = OSC_SAW;
        m_phase = '0;
        for (int i = 0; i < NUM_VOICES; i++)
            m_dphase[i] = 24'((longint'(((i + 1) * 137) % 1000) << 24) / 1000);
        m_cur_inc = 32'd10713070;
        m_tgt_inc = 32'd10713070;
        m_env = '0;
        m_gate = 1'b0;
        m_lp = 0;
        m_bp = 0;
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CUTOFF_BASE: m_cut_base = data[14:0];
            CFG_ENV_AMOUNT:  m_env_amt  = data[15:0];
            CFG_MIN_CUTOFF:  m_min_cut  = data[14:0];
            CFG_DAMPING:     m_damp     = data[15:0];
            CFG_DECAY_COEFF: m_decay    = data;
            CFG_OSC_MODE:    m_osc      = data[1:0];
            default: ;
        endcase
    endtask

    function automatic longint saw_q24(input logic [23:0] ph);
        return 2 * longint'(ph) - (64'sd1 << 24);
    endfunction

    // one oscillator sample, advancing phases
    task automatic run_oscillator(output longint s);
        logic [31:0] di;
        m_phase = m_phase + 24'(m_cur_inc >> 8);
        s = saw_q24(m_phase);
        if (m_osc == OSC_SQUARE) begin
            s = (s >= 0) ? (64'sd1 << 24) : -(64'sd1 << 24);
        end else if (m_osc == OSC_SUPER) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                di = 32'((longint'(m_cur_inc) * detune_q16[i % 6]) >> 24);
                m_dphase[i] = m_dphase[i] + di[23:0];
                s = s + saw_q24(m_dphase[i]);
            end
            s = s / (NUM_VOICES - 1);
        end
    endtask

    function automatic longint tanh_drive(input longint x);
        longint mag, pos, idx, y;
        mag = (x < 0) ? -x : x;
        pos = mag * TANH_DEPTH;
        idx = pos >> 26;
        if (idx >= TANH_DEPTH) y = tanh_q30[TANH_DEPTH];
        else y = tanh_q30[idx]
                 + (((tanh_q30[idx+1] - tanh_q30[idx]) * (pos & ((64'sd1 << 26) - 1))) >>> 26);
        y = (y + 32) >>> 6;
        return (x < 0) ? -y : y;
    endfunction

    // returns 1 when the item yields a sample
    task automatic predict_voice(input logic [1:0] kind, input logic [22:0] inc,
                                 input logic acc, input logic sl,
                                 output bit has_out, output logic [23:0] sample);
        longint osc, diff, step, cutoff, pos, idx, fq, q, hp, bp, lp;
        has_out = 0;
        sample  = '0;
        if (kind == KIND_NOTE) begin
            if (!sl) m_cur_inc = {1'b0, inc, 8'd0};
            m_tgt_inc = {1'b0, inc, 8'd0};
            m_gate = 1'b1;
            m_env = acc ? ENV_TWO : ENV_ONE;
        end else if (kind == KIND_RELEASE) begin
            m_gate = 1'b0;
        end else if (kind == KIND_TICK) begin
            has_out = 1;
            if (m_gate || m_env >= 24'd419) begin
                run_oscillator(osc);
                diff = longint'(m_tgt_inc) - longint'(m_cur_inc);
                step = (((diff < 0) ? -diff : diff) * 64'd4294967) >> 32;
                if (diff < 0) m_cur_inc = m_cur_inc - 32'(step);
                else m_cur_inc = m_cur_inc + 32'(step);
                if (m_gate || m_env > 24'd419)
                    m_env = 24'((longint'(m_env) * longint'(m_decay)) >> 24);
                cutoff = longint'(m_cut_base) + ((longint'(m_env_amt) * longint'(m_env)) >> 22);
                if (cutoff < m_min_cut) cutoff = m_min_cut;
                if (cutoff > 29491) cutoff = 29491;
                pos = cutoff * 2 * SINE_DEPTH;
                idx = pos >> 16;
                fq  = sine_q30[idx] + (((sine_q30[idx+1] - sine_q30[idx]) * (pos & 16'hFFFF)) >>> 16);
                fq  = (fq + 4096) >>> 13;
                q   = (m_damp < 16'd3932) ? 3932 : longint'(m_damp);
                hp  = osc - m_lp - ((q * m_bp) >>> 16);
                bp  = m_bp + ((fq * hp) >>> 16);
                lp  = m_lp + ((fq * bp) >>> 16);
                if (lp > (64'sd50 << 24)) lp = 64'sd50 << 24;
                if (lp < -(64'sd50 << 24)) lp = -(64'sd50 << 24);
                m_lp = lp;
                m_bp = tanh_drive((bp * 85197) >>> 16);
                sample = 24'((lp * 19661) >>> 21);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_item(input logic [1:0] kind, input logic [22:0] inc,
                             input logic acc, input logic sl,
                             input bit typed, input logic [23:0] typed_val);
        int gap;
        bit has_out;
        logic [23:0] sample;
        gap = tx_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.kind = kind;
        in_ch.note_increment = inc;
        in_ch.accent = acc;
        in_ch.slide = sl;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_voice(kind, inc, acc, sl, has_out, sample);
        if (has_out) expected_samples.push_back(typed ? typed_val : sample);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg_write(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // block until idle: all results in, then a drain wait before the next phase
    task automatic wait_quiet();
        in_ch.valid = 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_item();
        int r;
        logic [22:0] inc;
        r   = $urandom_range(0, 99);
        inc = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(20000, 400000));
        if (r < 12) send_item(KIND_NOTE, inc, 1'($urandom), 1'($urandom), 0, '0);
        else if (r < 17) send_item(KIND_RELEASE, 23'($urandom), 1'($urandom), 1'($urandom), 0, '0);
        else if (r < 20) send_item(KIND_BAD, 23'($urandom), 1'($urandom), 1'($urandom), 0, '0);
        else send_item(KIND_TICK, 23'($urandom), 1'($urandom), 1'($urandom), 0, '0);
    endtask

    // ---------------------------------------------------------------
    // Directed table; typed values are silent-voice zeros
    // ---------------------------------------------------------------
    typedef struct packed {
        logic [1:0]  kind;
        logic [22:0] inc;
        logic        acc;
        logic        sl;
        logic        typed;
        logic [23:0] val;
    } t_row;

    localparam int N_ROWS = 22;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b1, 24'd0},  // silent after reset
        '{KIND_BAD,     23'h7FFFFF,  1'b1, 1'b1, 1'b0, 24'd0},  // unknown kind dropped
        '{KIND_TICK,    23'h7FFFFF,  1'b1, 1'b1, 1'b1, 24'd0},
        '{KIND_RELEASE, 23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b1, 24'd0},
        '{KIND_NOTE,    23'h7FFFFF,  1'b1, 1'b0, 1'b0, 24'd0},  // top pitch, accent
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_NOTE,    23'd0,       1'b0, 1'b1, 1'b0, 24'd0},  // slide down to zero
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_RELEASE, 23'h7FFFFF,  1'b1, 1'b1, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_NOTE,    23'd200000,  1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_NOTE,    23'd400000,  1'b1, 1'b1, 1'b0, 24'd0},  // accented slide up
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_RELEASE, 23'd0,       1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TICK,    23'd0,       1'b0, 1'b0, 1'b0, 24'd0}
    };

    // ---------------------------------------------------------------
    // Result checker: outputs sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_samples.size() == 0) begin
                $error("audio_sample: unexpected transfer, actual %0d", out_ch.audio_sample);
                error_count++;
            end else begin
                if (out_ch.audio_sample !== expected_samples[0]) begin
                    $error("audio_sample: expected %0d, actual %0d",
                           $signed(expected_samples[0]), out_ch.audio_sample);
                    error_count++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    // Receiver: random wait per result, plus an optional long hold-off
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_len > 0) begin
                out_ch.ready = 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
            end
            gap = rx_idle_en ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int sent;
        error_count = 0;
        cycle_count = 0;
        tx_idle_en  = 1;
        rx_idle_en  = 1;
        rx_hold_len = 0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_TICK;
        in_ch.note_increment = '0;
        in_ch.accent = 1'b0;
        in_ch.slide = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_CUTOFF_BASE;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        build_voice_tables();
        voice_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at reset settings
        for (int r = 0; r < N_ROWS; r++)
            send_item(DIRECTED[r].kind, DIRECTED[r].inc, DIRECTED[r].acc, DIRECTED[r].sl,
                      DIRECTED[r].typed, DIRECTED[r].val);

        for (int p = 0; p < PHASES; p++) begin
            wait_quiet();
            case (p)
                0: begin  // every register at all ones; upper bits dropped, mode acts as saw
                    write_reg(CFG_CUTOFF_BASE, '1);
                    write_reg(CFG_ENV_AMOUNT, '1);
                    write_reg(CFG_MIN_CUTOFF, '1);
                    write_reg(CFG_DAMPING, '1);
                    write_reg(CFG_DECAY_COEFF, '1);
                    write_reg(CFG_OSC_MODE, {22'd0, OSC_SPARE});
                end
                1: begin  // all zero but square mode: damping raised to its floor, envelope dies at once
                    write_reg(CFG_CUTOFF_BASE, '0);
                    write_reg(CFG_ENV_AMOUNT, '0);
                    write_reg(CFG_MIN_CUTOFF, '0);
                    write_reg(CFG_DAMPING, '0);
                    write_reg(CFG_DECAY_COEFF, '0);
                    write_reg(CFG_OSC_MODE, {22'd0, OSC_SQUARE});
                    write_reg(CFG_SPARE6, 24'($urandom));
                end
                default: begin
                    write_reg(CFG_CUTOFF_BASE, 24'($urandom_range(0, 29491)));
                    write_reg(CFG_ENV_AMOUNT, 24'($urandom));
                    write_reg(CFG_MIN_CUTOFF, 24'($urandom_range(0, 4000)));
                    write_reg(CFG_DAMPING, 24'($urandom_range(2000, 65535)));
                    // mostly slow decays so notes ring across many ticks
                    write_reg(CFG_DECAY_COEFF, ($urandom_range(0, 3) == 0) ?
                              24'($urandom) : 24'($urandom_range(24'hF00000, 24'hFFFFFF)));
                    write_reg(CFG_OSC_MODE, (p % 2 == 0) ? {22'd0, OSC_SUPER} :
                              24'($urandom_range(0, 3)));
                    if (p == 5) write_reg(CFG_SPARE7, 24'($urandom));
                end
            endcase
            // one phase without idling on either side
            tx_idle_en = (p != 3);
            rx_idle_en = (p != 3);
            if (p == 4) rx_hold_len = HOLD_CYCLES;  // output backs up, input stalls
            send_item(KIND_NOTE, 23'($urandom_range(20000, 400000)), 1'($urandom), 1'b0, 0, '0);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                random_item();
                if (in_ch.kind != KIND_BAD) sent++;
            end
        end

        in_ch.valid = 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
